@@ hw/rtl/lkoc_pkg.sv @@
// Shared constants and item types for the keyed object cache.
package lkoc_pkg;

	// Cache geometry
	localparam int ENTRIES  = 4096;
	localparam int KEY_BITS = 64;

	// Port field widths
	localparam int KEY_W   = 64;
	localparam int SLOT_W  = 12;
	localparam int OCC_W   = 13;
	localparam int STAMP_W = 32;

	// Derived widths
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int RAM_W = KEY_BITS + STAMP_W;

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Request handed from the port side to the engine
	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	// Result handed from the engine to the output register
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [OCC_W-1:0]  occupancy;
	} res_t;

endpackage

@@ hw/rtl/lkoc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lkoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lkoc_engine.sv @@
// Scan, replacement and write-back sequencer around the entry memory.
module lkoc_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lkoc_pkg::req_t req,
	output logic           busy,
	output logic           done,
	input  logic           ack,
	output lkoc_pkg::res_t res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	localparam logic [lkoc_pkg::CNT_W-1:0] FULL = lkoc_pkg::CNT_W'(lkoc_pkg::ENTRIES);

	logic [2:0]                          state_q;
	logic                                cmd_q;
	logic [lkoc_pkg::KEY_BITS-1:0]       key_q;
	logic [lkoc_pkg::CNT_W-1:0]          count_q;
	logic [lkoc_pkg::STAMP_W-1:0]        ctr_q;
	logic [lkoc_pkg::CNT_W-1:0]          rd_addr_q;
	logic                                chk_valid_s1;
	logic [lkoc_pkg::IDX_W-1:0]          chk_addr_s1;
	logic                                have_old_q;
	logic [lkoc_pkg::IDX_W-1:0]          old_slot_q;
	logic [lkoc_pkg::STAMP_W-1:0]        old_stamp_q;
	logic [lkoc_pkg::IDX_W-1:0]          target_q;
	lkoc_pkg::res_t                      res_q;

	logic                                ram_we;
	logic [lkoc_pkg::IDX_W-1:0]          ram_raddr;
	logic [lkoc_pkg::RAM_W-1:0]          ram_wdata;
	logic [lkoc_pkg::RAM_W-1:0]          ram_rdata;
	logic [lkoc_pkg::KEY_BITS-1:0]       rd_key;
	logic [lkoc_pkg::STAMP_W-1:0]        rd_stamp;
	logic                                key_match;
	logic                                older;
	logic [lkoc_pkg::IDX_W-1:0]          old_slot_n;
	logic                                last_chk;
	logic                                issue;

	// Entry memory: key in the upper bits, stamp in the lower bits
	lkoc_ram #(
		.WIDTH(lkoc_pkg::RAM_W),
		.DEPTH(lkoc_pkg::ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(target_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Split read data and evaluate the entry returned this cycle
	always_comb begin
		rd_key     = ram_rdata[lkoc_pkg::RAM_W-1:lkoc_pkg::STAMP_W];
		rd_stamp   = ram_rdata[lkoc_pkg::STAMP_W-1:0];
		key_match  = (rd_key == key_q);
		older      = !have_old_q || (rd_stamp < old_stamp_q);
		old_slot_n = older ? chk_addr_s1 : old_slot_q;
		last_chk   = ((lkoc_pkg::CNT_W'(chk_addr_s1) + lkoc_pkg::CNT_W'(1)) == count_q);
		issue      = (rd_addr_q < count_q);
		ram_raddr  = (state_q == ST_START) ? '0 : rd_addr_q[lkoc_pkg::IDX_W-1:0];
		ram_we     = (state_q == ST_WRITE);
		ram_wdata  = {key_q, ctr_q};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ctr_q        <= '0;
			chk_valid_s1 <= 1'b0;
			have_old_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					chk_valid_s1 <= 1'b0;
					if (start) begin
						cmd_q   <= req.cmd;
						key_q   <= req.key[lkoc_pkg::KEY_BITS-1:0];
						state_q <= ST_START;
					end
				end
				ST_START: begin
					have_old_q <= 1'b0;
					if (cmd_q == lkoc_pkg::CMD_CLEAR) begin
						// Empty the store; the use counter keeps running
						count_q <= '0;
						res_q   <= '0;
						state_q <= ST_RESP;
					end else if (count_q == '0) begin
						// Empty cache: insert at slot zero without a scan
						target_q          <= '0;
						count_q           <= lkoc_pkg::CNT_W'(1);
						res_q.hit         <= 1'b0;
						res_q.slot        <= '0;
						res_q.evicted     <= 1'b0;
						res_q.occupancy   <= lkoc_pkg::OCC_W'(1);
						state_q           <= ST_WRITE;
					end else begin
						// Read slot zero, queue slot one
						chk_valid_s1 <= 1'b1;
						chk_addr_s1  <= '0;
						rd_addr_q    <= lkoc_pkg::CNT_W'(1);
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_valid_s1 <= issue;
					chk_addr_s1  <= rd_addr_q[lkoc_pkg::IDX_W-1:0];
					if (issue) begin
						rd_addr_q <= rd_addr_q + lkoc_pkg::CNT_W'(1);
					end
					if (chk_valid_s1) begin
						if (key_match) begin
							// Hit: restamp this entry
							target_q        <= chk_addr_s1;
							res_q.hit       <= 1'b1;
							res_q.slot      <= lkoc_pkg::SLOT_W'(chk_addr_s1);
							res_q.evicted   <= 1'b0;
							res_q.occupancy <= lkoc_pkg::OCC_W'(count_q);
							chk_valid_s1    <= 1'b0;
							state_q         <= ST_WRITE;
						end else begin
							have_old_q  <= 1'b1;
							old_slot_q  <= old_slot_n;
							if (older) begin
								old_stamp_q <= rd_stamp;
							end
							if (last_chk) begin
								chk_valid_s1 <= 1'b0;
								res_q.hit    <= 1'b0;
								state_q      <= ST_WRITE;
								if (count_q != FULL) begin
									// Fill the lowest free slot
									target_q        <= count_q[lkoc_pkg::IDX_W-1:0];
									count_q         <= count_q + lkoc_pkg::CNT_W'(1);
									res_q.slot      <= lkoc_pkg::SLOT_W'(count_q);
									res_q.evicted   <= 1'b0;
									res_q.occupancy <= lkoc_pkg::OCC_W'(count_q)
										+ lkoc_pkg::OCC_W'(1);
								end else begin
									// Replace the oldest entry
									target_q        <= old_slot_n;
									res_q.slot      <= lkoc_pkg::SLOT_W'(old_slot_n);
									res_q.evicted   <= 1'b1;
									res_q.occupancy <= lkoc_pkg::OCC_W'(count_q);
								end
							end
						end
					end
				end
				ST_WRITE: begin
					// Write key and stamp, advance the counter
					ctr_q   <= ctr_q + lkoc_pkg::STAMP_W'(1);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);
	assign res  = res_q;

	// Fill count never passes the cache size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count above cache size");

	// Every entry checked during a scan lies below the fill count
	a_chk_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_valid_s1) |-> (lkoc_pkg::CNT_W'(chk_addr_s1) < count_q))
		else $error("scan checked an entry past the fill count");

	// Writes land on a valid slot
	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (lkoc_pkg::CNT_W'(target_q) < count_q))
		else $error("write outside valid slots");

	// The use counter advances exactly once per write
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (ctr_q == $past(ctr_q) + lkoc_pkg::STAMP_W'(1)))
		else $error("use counter did not advance on write");

endmodule

@@ hw/rtl/lru_keyed_object_cache.sv @@
// Throughput: one item at a time; the next item is taken once the result is registered,
// and a lookup is bounded by the one-entry-per-cycle memory scan.
// The fill count marks valid entries, so clear and reset need no pass over the memory.
// Reset (arst_n, asynchronous): empty cache, use counter zero, no result pending.
// Top level of the fully associative LRU key cache.
module lru_keyed_object_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [lkoc_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [lkoc_pkg::SLOT_W-1:0] slot,
	output logic                        evicted,
	output logic [lkoc_pkg::OCC_W-1:0]  occupancy
);

	lkoc_pkg::req_t req;
	lkoc_pkg::res_t eng_res;
	lkoc_pkg::res_t out_q;
	logic           out_valid_q;
	logic           eng_busy;
	logic           eng_done;
	logic           slot_free;
	logic           accept;

	assign req.cmd   = cmd;
	assign req.key   = key;
	assign in_stall  = eng_busy;
	assign accept    = in_valid && !eng_busy;
	assign slot_free = !out_valid_q || !out_stall;

	lkoc_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.req   (req),
		.busy  (eng_busy),
		.done  (eng_done),
		.ack   (slot_free),
		.res   (eng_res)
	);

	// Output register: load a finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_done && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done && slot_free) begin
			out_q <= eng_res;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_q.hit;
	assign slot      = out_q.slot;
	assign evicted   = out_q.evicted;
	assign occupancy = out_q.occupancy;

	// An accepted item blocks further input until its result is handed over
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after accept");

	// A result is only loaded while the engine is busy with an item
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> eng_busy)
		else $error("result offered while engine idle");

endmodule

@@ tb/lru_keyed_object_cache_tb.sv @@
// Self-checking testbench for the fully associative LRU key cache: lookups, fills, clears.
module lru_keyed_object_cache_tb;
	import lkoc_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam int RUN_LIMIT = 1_000_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = CMD_LOOKUP;
	logic [KEY_W-1:0]    key = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [SLOT_W-1:0]   slot;
	logic                evicted;
	logic [OCC_W-1:0]    occupancy;

	// Shadow copy of the cache contents
	logic                line_valid [ENTRIES];
	logic [KEY_W-1:0]    line_key   [ENTRIES];
	logic [STAMP_W-1:0]  line_stamp [ENTRIES];
	logic [STAMP_W-1:0]  access_ctr = '0;
	logic [OCC_W-1:0]    line_count = '0;

	res_t                pending_results [$];

	bit                  calm = 1'b0;
	int                  fail_count = 0;
	int                  n_items = 0;
	int                  n_hits = 0;
	int                  n_evictions = 0;
	int                  n_clears = 0;

	lru_keyed_object_cache uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.slot      (slot),
		.evicted   (evicted),
		.occupancy (occupancy)
	);

	// Clock: 12 units per period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Compute the result of one cache access and update the shadow state
	function automatic res_t predict_cache_access(logic c, logic [KEY_W-1:0] k_in);
		logic [KEY_W-1:0] k;
		bit               have_free;
		bit               have_old;
		int               free_idx;
		int               old_idx;
		int               tgt;
		res_t             r;
		k = k_in & KEY_MASK;
		r = '0;
		have_free = 1'b0;
		have_old = 1'b0;
		free_idx = 0;
		old_idx = 0;
		if (c == CMD_CLEAR) begin
			foreach (line_valid[i])
				line_valid[i] = 1'b0;
			line_count = '0;
			return r;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (line_valid[i]) begin
				if (line_key[i] == k) begin
					line_stamp[i] = access_ctr;
					access_ctr = access_ctr + 1'b1;
					r.hit = 1'b1;
					r.slot = SLOT_W'(i);
					r.occupancy = line_count;
					return r;
				end
				if (!have_old || line_stamp[i] < line_stamp[old_idx]) begin
					have_old = 1'b1;
					old_idx = i;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_idx = i;
			end
		end
		if (have_free) begin
			tgt = free_idx;
			line_valid[tgt] = 1'b1;
			line_count = line_count + 1'b1;
		end else begin
			tgt = old_idx;
			r.evicted = 1'b1;
		end
		line_key[tgt] = k;
		line_stamp[tgt] = access_ctr;
		access_ctr = access_ctr + 1'b1;
		r.slot = SLOT_W'(tgt);
		r.occupancy = line_count;
		return r;
	endfunction

	// Offer one item, hold it until accepted, then queue its expected result
	task automatic send_request(input logic c, input logic [KEY_W-1:0] k);
		int   gap;
		res_t res;
		gap = pick_idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		res = predict_cache_access(c, k);
		pending_results.push_back(res);
		n_items++;
		if (c == CMD_CLEAR)
			n_clears++;
		if (res.hit)
			n_hits++;
		if (res.evicted)
			n_evictions++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Directed lookups and clears on an almost empty cache
	task automatic test_basic_lookups();
		send_request(CMD_CLEAR, '0);
		send_request(CMD_LOOKUP, '0);
		send_request(CMD_LOOKUP, '1);
		send_request(CMD_LOOKUP, '1);
		send_request(CMD_LOOKUP, '0);
		send_request(CMD_LOOKUP, 64'h8000_0000_0000_0001);
		send_request(CMD_LOOKUP, 64'h5555_5555_5555_5555);
		send_request(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_LOOKUP, 64'h5555_5555_5555_5555);
		send_request(CMD_LOOKUP, 64'h8000_0000_0000_0001);
		// One bit away from a stored key must miss
		send_request(CMD_LOOKUP, 64'h8000_0000_0000_0000);
		send_request(CMD_LOOKUP, 64'h0000_0000_0000_0001);
		send_request(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_CLEAR, '1);
		send_request(CMD_LOOKUP, '1);
		send_request(CMD_CLEAR, 64'h1234_5678_9ABC_DEF0);
		send_request(CMD_CLEAR, '0);
		send_request(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF);
		drain();
	endtask

	// Random mix of repeated keys, fresh keys and clears
	task automatic test_random_mix();
		logic [KEY_W-1:0] pool [16];
		int               r;
		foreach (pool[i])
			pool[i] = rand_key();
		for (int n = 0; n < 122; n++) begin
			// No idling on either side for one stretch
			calm = (n >= 50 && n < 80);
			r = $urandom_range(0, 99);
			if (r < 6)
				send_request(CMD_CLEAR, rand_key());
			else if (r < 52)
				send_request(CMD_LOOKUP, pool[$urandom_range(0, 15)]);
			else
				send_request(CMD_LOOKUP, rand_key());
		end
		calm = 1'b0;
		drain();
	endtask

	// Stall the result side in bursts
	initial begin : out_stall_gen
		int open_len;
		int hold_len;
		wait (arst_n === 1'b1);
		forever begin
			open_len = $urandom_range(1, 24);
			repeat (open_len) @(posedge clk);
			hold_len = pick_idle_len();
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with no pending item: hit=%0d slot=%0d evicted=%0d occupancy=%0d",
					hit, slot, evicted, occupancy);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					fail_count++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, evicted);
					fail_count++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
					fail_count++;
				end
			end
		end
	end

	// Hard stop for a hung run
	initial begin
		#(RUN_LIMIT);
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		foreach (line_valid[i]) begin
			line_valid[i] = 1'b0;
			line_key[i] = '0;
			line_stamp[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_lookups();
		test_random_mix();

		// Give a stray result time to show up
		repeat (16) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		$display("Sent %0d items: %0d hits, %0d evictions, %0d clears.",
			n_items, n_hits, n_evictions, n_clears);
		$display("Directed near misses and clears plus a random mix with gaps; %0d mismatches.",
			fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
